[rtl/wld_pkg.sv]
package wld_pkg;

  // sizes fixed by the field formats
  localparam int NUM_LINKS_DEF  = 4;
  localparam int REG_LINKS      = 4;
  localparam int SHARE_W        = 15;
  localparam int CREDIT_W       = 16;
  localparam int TAG_W          = 16;
  localparam int MASK_W         = 4;
  localparam int USE_W          = 3;
  localparam int ADDR_W         = 5;
  localparam int DATA_W         = 32;
  localparam int REFILL_PERIOD  = 100;
  localparam int REFILL_W       = 7;

  // credit constants, q8.8
  localparam logic [CREDIT_W-1:0] CREDIT_MAX       = 16'hFFFF;
  localparam logic [CREDIT_W-1:0] CREDIT_MINUS_ONE = 16'hFF00;

  // register reset values
  localparam logic [SHARE_W-1:0] SHARE_RST  = 15'd6400;
  localparam logic [MASK_W-1:0]  MASTER_RST = 4'd1;
  localparam logic [USE_W-1:0]   USE_RST    = 3'd4;

  // register index, from paddr word address
  typedef enum logic [2:0] {
    REG_SHARE0 = 3'd0,
    REG_SHARE1 = 3'd1,
    REG_SHARE2 = 3'd2,
    REG_SHARE3 = 3'd3,
    REG_MASTER = 3'd4,
    REG_IN_USE = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [REG_LINKS-1:0][SHARE_W-1:0] share;
    logic [MASK_W-1:0]                 master_mask;
    logic [USE_W-1:0]                  links_in_use;
  } cfg_t;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [MASK_W-1:0] dest;
    logic              gap;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PICK,
    ST_DONE
  } eng_state_e;

endpackage

[rtl/wld_cfg_regs.sv]
module wld_cfg_regs
  import wld_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t     cfg_q;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_e'(paddr[ADDR_W-1:2]);
  assign cfg_o  = cfg_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < REG_LINKS; j++) begin
        cfg_q.share[j] <= SHARE_RST;
      end
      cfg_q.master_mask  <= MASTER_RST;
      cfg_q.links_in_use <= USE_RST;
    end else if (wr_en) begin
      case (idx)
        REG_SHARE0: cfg_q.share[0]     <= pwdata[SHARE_W-1:0];
        REG_SHARE1: cfg_q.share[1]     <= pwdata[SHARE_W-1:0];
        REG_SHARE2: cfg_q.share[2]     <= pwdata[SHARE_W-1:0];
        REG_SHARE3: cfg_q.share[3]     <= pwdata[SHARE_W-1:0];
        REG_MASTER: cfg_q.master_mask  <= pwdata[MASK_W-1:0];
        REG_IN_USE: cfg_q.links_in_use <= pwdata[USE_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    case (idx)
      REG_SHARE0: prdata = DATA_W'(cfg_q.share[0]);
      REG_SHARE1: prdata = DATA_W'(cfg_q.share[1]);
      REG_SHARE2: prdata = DATA_W'(cfg_q.share[2]);
      REG_SHARE3: prdata = DATA_W'(cfg_q.share[3]);
      REG_MASTER: prdata = DATA_W'(cfg_q.master_mask);
      REG_IN_USE: prdata = DATA_W'(cfg_q.links_in_use);
      default:    prdata = '0;
    endcase
  end

endmodule

[rtl/wld_phase.sv]
module wld_phase
  import wld_pkg::*;
#(
  parameter int NUM_LINKS = NUM_LINKS_DEF,
  localparam int CNT_W = $clog2(NUM_LINKS + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             advance_i,
  input  logic [CNT_W-1:0] count_i,
  output logic             refill_o,
  output logic [CNT_W-1:0] pick_o
);

  // packet count kept as residues: modulo the refill period and modulo
  // every possible eligible count
  logic [REFILL_W-1:0] refill_cnt_q;
  logic [CNT_W-1:0]    res_q [NUM_LINKS+1];

  assign refill_o = (refill_cnt_q == '0);
  assign pick_o   = res_q[count_i];

  // residue counters advance once per finished word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      refill_cnt_q <= '0;
      for (int k = 0; k <= NUM_LINKS; k++) begin
        res_q[k] <= '0;
      end
    end else if (advance_i) begin
      if (refill_cnt_q == REFILL_W'(REFILL_PERIOD - 1)) begin
        refill_cnt_q <= '0;
      end else begin
        refill_cnt_q <= refill_cnt_q + 1'b1;
      end
      for (int k = 0; k <= NUM_LINKS; k++) begin
        if (k == 0) begin
          res_q[k] <= '0;
        end else if (res_q[k] == CNT_W'(k - 1)) begin
          res_q[k] <= '0;
        end else begin
          res_q[k] <= res_q[k] + 1'b1;
        end
      end
    end
  end

endmodule

[rtl/wld_engine.sv]
module wld_engine
  import wld_pkg::*;
#(
  parameter int NUM_LINKS = NUM_LINKS_DEF,
  localparam int LINK_W = $clog2(NUM_LINKS),
  localparam int CNT_W  = $clog2(NUM_LINKS + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             start_i,
  input  logic [TAG_W-1:0] tag_i,
  input  logic             refill_i,
  input  logic [CNT_W-1:0] pick_i,
  input  logic             out_free_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [CNT_W-1:0] count_o,
  output result_t          result_o
);

  eng_state_e          state_q, state_d;
  logic [LINK_W-1:0]   idx_q, idx_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [CNT_W-1:0]    seen_q, seen_d;
  logic                refill_q, refill_d;
  result_t             res_q, res_d;
  logic [CREDIT_W-1:0] credit_q [NUM_LINKS];

  logic                last;
  logic                act;
  logic [SHARE_W-1:0]  share;
  logic [CREDIT_W-1:0] rd;
  logic [CREDIT_W-1:0] op_b;
  logic [CREDIT_W:0]   sum;
  logic [CREDIT_W-1:0] scan_val;
  logic [CREDIT_W-1:0] wr_val;
  logic                cr_we;
  logic                scan_elig;
  logic                pick_elig;
  logic [CNT_W-1:0]    cnt_inc;
  logic [MASK_W-1:0]   act_mask;
  logic [MASK_W-1:0]   one_hot;

  assign busy_o   = (state_q != ST_IDLE);
  assign done_o   = (state_q == ST_DONE) && out_free_i;
  assign count_o  = cnt_q;
  assign result_o = res_q;

  // per-link decode of the current index
  assign last = (idx_q == LINK_W'(NUM_LINKS - 1));
  assign act  = (int'(idx_q) < int'(cfg_i.links_in_use));
  always_comb begin
    share   = '0;
    one_hot = '0;
    for (int j = 0; j < REG_LINKS; j++) begin
      if (int'(idx_q) == j) begin
        share      = cfg_i.share[j];
        one_hot[j] = 1'b1;
      end
    end
  end

  // masters among active links
  always_comb begin
    act_mask = '0;
    for (int j = 0; j < MASK_W; j++) begin
      act_mask[j] = (j < NUM_LINKS) && (j < int'(cfg_i.links_in_use));
    end
  end

  // shared credit adder: on scan add share to active links in a refill packet, add minus one on pick
  assign rd   = credit_q[idx_q];
  always_comb begin
    op_b = '0;
    if (state_q == ST_PICK) begin
      op_b = CREDIT_MINUS_ONE;
    end else if (refill_q && act) begin
      op_b = CREDIT_W'(share);
    end
  end
  assign sum       = {1'b0, rd} + {1'b0, op_b};
  assign scan_val  = sum[CREDIT_W] ? CREDIT_MAX : sum[CREDIT_W-1:0];
  assign scan_elig = act && (scan_val[CREDIT_W-1:8] != '0);
  assign pick_elig = act && (rd[CREDIT_W-1:8] != '0);
  assign cnt_inc   = scan_elig ? cnt_q + 1'b1 : cnt_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (start_i) state_d = ST_SCAN;
      ST_SCAN: begin
        if (last) state_d = (cnt_inc == '0) ? ST_DONE : ST_PICK;
      end
      ST_PICK: if (pick_elig && seen_q == pick_i) state_d = ST_DONE;
      ST_DONE: if (out_free_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    idx_d    = idx_q;
    cnt_d    = cnt_q;
    seen_d   = seen_q;
    refill_d = refill_q;
    res_d    = res_q;
    cr_we    = 1'b0;
    wr_val   = scan_val;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          idx_d     = '0;
          cnt_d     = '0;
          seen_d    = '0;
          refill_d  = refill_i;
          res_d.tag = tag_i;
        end
      end
      ST_SCAN: begin
        cr_we  = 1'b1;
        wr_val = scan_val;
        cnt_d  = cnt_inc;
        idx_d  = last ? '0 : idx_q + 1'b1;
        if (last && cnt_inc == '0) begin
          res_d.dest = cfg_i.master_mask & act_mask;
          res_d.gap  = 1'b1;
        end
      end
      ST_PICK: begin
        if (pick_elig && seen_q == pick_i) begin
          cr_we      = 1'b1;
          wr_val     = sum[CREDIT_W-1:0];
          res_d.dest = one_hot;
          res_d.gap  = 1'b0;
        end else begin
          if (pick_elig) seen_d = seen_q + 1'b1;
          if (!last) idx_d = idx_q + 1'b1;
        end
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      idx_q    <= '0;
      cnt_q    <= '0;
      seen_q   <= '0;
      refill_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      cnt_q    <= cnt_d;
      seen_q   <= seen_d;
      refill_q <= refill_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  // link credits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_LINKS; k++) begin
        credit_q[k] <= '0;
      end
    end else if (cr_we) begin
      credit_q[idx_q] <= wr_val;
    end
  end

endmodule

[rtl/weighted_link_distributor.sv]
// Weighted link distributor: routes each packet word to one link of a bonding
// group by percentage credit, or to the active masters when no link has credit,
// one credit register visited per cycle through a single shared adder. One
// pass over the links adds shares on refill packets and counts eligible links;
// when any link is eligible, a second pass walks to the chosen link and takes
// one credit. The input is stalled while a packet is in work; the result sits in
// an output register so the next packet is taken while it waits. Shares, master
// mask and links in use must be written over the APB port only while no packet
// is in work; the block itself does not enforce this.
module weighted_link_distributor
  import wld_pkg::*;
#(
  parameter int NUM_LINKS = NUM_LINKS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [TAG_W-1:0]  packet_tag_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [TAG_W-1:0]  tag_out_o,
  output logic [MASK_W-1:0] dest_mask_o,
  output logic              gap_cover_o
);

  localparam int CNT_W = $clog2(NUM_LINKS + 1);

  cfg_t             cfg;
  logic             busy;
  logic             done;
  logic             start;
  logic             refill;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] pick;
  logic             out_free;
  result_t          result;
  logic             out_valid_q;
  result_t          out_q;

  assign in_stall_o = busy;
  assign start      = in_valid_i & ~busy;
  assign out_free   = ~out_valid_q | ~out_stall_i;

  wld_cfg_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  wld_phase #(
    .NUM_LINKS (NUM_LINKS)
  ) u_phase (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (done),
    .count_i   (count),
    .refill_o  (refill),
    .pick_o    (pick)
  );

  wld_engine #(
    .NUM_LINKS (NUM_LINKS)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .start_i    (start),
    .tag_i      (packet_tag_i),
    .refill_i   (refill),
    .pick_i     (pick),
    .out_free_i (out_free),
    .busy_o     (busy),
    .done_o     (done),
    .count_o    (count),
    .result_o   (result)
  );

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign tag_out_o   = out_q.tag;
  assign dest_mask_o = out_q.dest;
  assign gap_cover_o = out_q.gap;

endmodule
